FILE: hdl/stt_pkg.sv
// Package for the software timer table: field widths, request opcodes,
// the token that travels along the slot chain, and the expiry record.
// No dependencies.
`default_nettype none

package stt_pkg;

   localparam int DEF_TIMER_SLOTS = 16;

   localparam int OPCODE_W = 2;
   localparam int IDENT_W  = 16;
   localparam int OWNER_W  = 8;
   localparam int COUNT_W  = 32;
   localparam int TICK_W   = 16;

   localparam logic [OPCODE_W-1:0] OP_SET    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_CANCEL = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd2;

   typedef enum logic [1:0] {
      TOK_MATCH,
      TOK_FILL,
      TOK_CANCEL,
      TOK_TICK
   } tok_op_type;

   typedef struct packed {
      logic                valid;
      tok_op_type          op;
      logic                done;
      logic [IDENT_W-1:0]  ident;
      logic [OWNER_W-1:0]  owner;
      logic [COUNT_W-1:0]  dur;
      logic [TICK_W-1:0]   elapsed;
   } token_type;

   typedef struct packed {
      logic                valid;
      logic [IDENT_W-1:0]  ident;
      logic [OWNER_W-1:0]  owner;
   } expiry_type;

endpackage

`default_nettype wire

FILE: hdl/stt_ifaces.sv
// Valid/ready channel interfaces for the software timer table.
// stt_req_if carries requests in, stt_rsp_if carries expiry results out.
// Depends on stt_pkg.
`default_nettype none

interface stt_req_if import stt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [IDENT_W-1:0]  timer_ident;
   logic [OWNER_W-1:0]  owner_task;
   logic [COUNT_W-1:0]  duration;
   logic [TICK_W-1:0]   now_tick;

   modport source (output valid, opcode, timer_ident, owner_task, duration, now_tick,
                   input ready);
   modport sink   (input valid, opcode, timer_ident, owner_task, duration, now_tick,
                   output ready);
endinterface

interface stt_rsp_if import stt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [IDENT_W-1:0] expired_timer;
   logic [OWNER_W-1:0] expired_owner;
   logic               last_of_run;

   modport source (output valid, expired_timer, expired_owner, last_of_run,
                   input ready);
   modport sink   (input valid, expired_timer, expired_owner, last_of_run,
                   output ready);
endinterface

`default_nettype wire

FILE: hdl/stt_cell.sv
// One timer slot: id, owner and remaining count, acted on by the token
// passing through, which it registers on to the next slot.
// Depends on stt_pkg.
`default_nettype none

module stt_cell import stt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  token_type  tok_in,
   output token_type  tok_out,
   output expiry_type exp_out
);

   logic [IDENT_W-1:0] ident_ff, ident_in;
   logic [OWNER_W-1:0] owner_ff, owner_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   token_type          fwd_ff, fwd_in;

   always_comb begin
      ident_in = ident_ff;
      owner_in = owner_ff;
      rem_in   = rem_ff;
      fwd_in   = tok_in;
      exp_out  = '0;
      if (advance && tok_in.valid) begin
         case (tok_in.op)
            TOK_MATCH: begin
               if (!tok_in.done && ident_ff == tok_in.ident && owner_ff == tok_in.owner) begin
                  rem_in      = tok_in.dur;
                  fwd_in.done = 1'b1;
               end
            end
            TOK_FILL: begin
               if (!tok_in.done && ident_ff == '0) begin
                  ident_in    = tok_in.ident;
                  owner_in    = tok_in.owner;
                  rem_in      = tok_in.dur;
                  fwd_in.done = 1'b1;
               end
            end
            TOK_CANCEL: begin
               if (!tok_in.done && ident_ff == tok_in.ident) begin
                  ident_in    = '0;
                  owner_in    = '0;
                  rem_in      = '0;
                  fwd_in.done = 1'b1;
               end
            end
            TOK_TICK: begin
               if (ident_ff != '0 && rem_ff != '0) begin
                  if (rem_ff > {{(COUNT_W-TICK_W){1'b0}}, tok_in.elapsed}) begin
                     rem_in = rem_ff - {{(COUNT_W-TICK_W){1'b0}}, tok_in.elapsed};
                  end else begin
                     exp_out.valid = 1'b1;
                     exp_out.ident = ident_ff;
                     exp_out.owner = owner_ff;
                     ident_in      = '0;
                     owner_in      = '0;
                     rem_in        = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ident_ff <= '0;
         owner_ff <= '0;
         rem_ff   <= '0;
         fwd_ff   <= '0;
      end else begin
         ident_ff <= ident_in;
         owner_ff <= owner_in;
         rem_ff   <= rem_in;
         if (advance) begin
            fwd_ff <= fwd_in;
         end
      end
   end

   assign tok_out = fwd_ff;

endmodule

`default_nettype wire

FILE: hdl/stt_ctrl.sv
// Request intake, tick bookkeeping, token launch and relaunch, and the
// expiry collector with its output register.
// Depends on stt_pkg and stt_ifaces.
`default_nettype none

module stt_ctrl import stt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   stt_req_if.sink      req,
   stt_rsp_if.source    rsp,
   output logic         advance,
   output token_type    tok_head,
   input  token_type    tok_tail,
   input  expiry_type   exp_in
);

   logic               busy_ff, busy_in;
   token_type          head_ff, head_in;
   logic [TICK_W-1:0]  prev_ff, prev_in;
   expiry_type         held_ff, held_in;
   logic               out_valid_ff, out_valid_in;
   logic [IDENT_W-1:0] out_ident_ff, out_ident_in;
   logic [OWNER_W-1:0] out_owner_ff, out_owner_in;
   logic               out_last_ff, out_last_in;
   logic               accept;
   logic               relaunch;

   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = !busy_ff;
   assign accept    = req.valid && !busy_ff;
   assign relaunch  = tok_tail.valid && tok_tail.op == TOK_MATCH && !tok_tail.done;

   always_comb begin
      busy_in      = busy_ff;
      head_in      = head_ff;
      prev_in      = prev_ff;
      held_in      = held_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_ident_in = out_ident_ff;
      out_owner_in = out_owner_ff;
      out_last_in  = out_last_ff;

      if (advance) begin
         head_in.valid = 1'b0;
         if (exp_in.valid) begin
            held_in = exp_in;
            if (held_ff.valid) begin
               out_valid_in = 1'b1;
               out_ident_in = held_ff.ident;
               out_owner_in = held_ff.owner;
               out_last_in  = 1'b0;
            end
         end
         if (tok_tail.valid) begin
            if (relaunch) begin
               head_in      = tok_tail;
               head_in.op   = TOK_FILL;
               head_in.done = 1'b0;
            end else begin
               busy_in = 1'b0;
               if (held_ff.valid) begin
                  out_valid_in  = 1'b1;
                  out_ident_in  = held_ff.ident;
                  out_owner_in  = held_ff.owner;
                  out_last_in   = 1'b1;
                  held_in.valid = 1'b0;
               end
            end
         end
      end

      if (accept) begin
         head_in.done    = 1'b0;
         head_in.ident   = req.timer_ident;
         head_in.owner   = req.owner_task;
         head_in.dur     = req.duration;
         head_in.elapsed = req.now_tick - prev_ff;
         head_in.op      = TOK_TICK;
         case (req.opcode)
            OP_SET: begin
               head_in.op    = TOK_MATCH;
               head_in.valid = req.timer_ident != '0;
               busy_in       = req.timer_ident != '0;
            end
            OP_CANCEL: begin
               head_in.op    = TOK_CANCEL;
               head_in.valid = req.timer_ident != '0;
               busy_in       = req.timer_ident != '0;
            end
            OP_TICK: begin
               head_in.valid = 1'b1;
               busy_in       = 1'b1;
               prev_in       = req.now_tick;
            end
            default: begin
               head_in.valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         head_ff       <= '0;
         prev_ff       <= '0;
         held_ff       <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         head_ff       <= head_in;
         prev_ff       <= prev_in;
         held_ff       <= held_in;
         out_valid_ff  <= out_valid_in;
      end
      out_ident_ff <= out_ident_in;
      out_owner_ff <= out_owner_in;
      out_last_ff  <= out_last_in;
   end

   assign tok_head          = head_ff;
   assign rsp.valid         = out_valid_ff;
   assign rsp.expired_timer = out_ident_ff;
   assign rsp.expired_owner = out_owner_ff;
   assign rsp.last_of_run   = out_last_ff;

endmodule

`default_nettype wire

FILE: hdl/software_timer_table.sv
// Software timer table, top level: controller plus a chain of timer slots.
// Depends on stt_pkg, stt_ifaces, stt_cell and stt_ctrl.
//
// Usage:
//  req_bus is a valid/ready request channel: set (opcode 0), cancel (1) and
//  tick (2). Opcode 3, and set or cancel with id 0, are taken and dropped.
//  rsp_bus carries one expiry result per slot that reaches zero on a tick,
//  in slot order, with last_of_run marking the final one of that tick.
//  A request launches a token that walks the slot chain one slot per
//  cycle while the chain is not held. Set, cancel and tick make one walk;
//  a set that matches no slot makes a second walk to fill the first free
//  slot. The next request is taken once the token leaves the last slot.
//  The last expiry of a tick is shown in the cycle after the walk ends.
//  While rsp_bus is stalled with a result waiting, the whole chain holds.
//  Synchronous reset frees all slots, zeroes the previous tick, and drops
//  any request in flight and any waiting result.
`default_nettype none

module software_timer_table import stt_pkg::*; #(
   parameter int TIMER_SLOTS = DEF_TIMER_SLOTS
) (
   input  logic      clock,
   input  logic      reset,
   stt_req_if.sink   req_bus,
   stt_rsp_if.source rsp_bus
);

   token_type  tok [TIMER_SLOTS+1];
   expiry_type exp_cell [TIMER_SLOTS];
   expiry_type exp_any;
   logic       advance;

   stt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .rsp      (rsp_bus),
      .advance  (advance),
      .tok_head (tok[0]),
      .tok_tail (tok[TIMER_SLOTS]),
      .exp_in   (exp_any)
   );

   for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_slot
      stt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_in  (tok[g]),
         .tok_out (tok[g+1]),
         .exp_out (exp_cell[g])
      );
   end

   // only the slot holding the token can report an expiry
   always_comb begin
      exp_any = '0;
      for (int i = 0; i < TIMER_SLOTS; i++) begin
         exp_any = exp_any | exp_cell[i];
      end
   end

endmodule

`default_nettype wire

FILE: tb/sv/stt_expiry_checker.sv
// Expiry checker for the software timer table: watches both channels, keeps its own
// copy of the timer slots and compares every expiry against the predicted one.
// Depends on stt_pkg and stt_ifaces.
module stt_expiry_checker import stt_pkg::*; #(
   parameter int TIMER_SLOTS = DEF_TIMER_SLOTS
) (
   input  logic clock,
   input  logic reset,
   stt_req_if   req_bus,
   stt_rsp_if   rsp_bus,
   output int   mismatches,
   output int   expiries_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [IDENT_W-1:0] ident;
      logic [OWNER_W-1:0] owner;
      logic               last_run;
   } expiry_rec_type;

   logic [IDENT_W-1:0] tbl_ident   [TIMER_SLOTS];
   logic [OWNER_W-1:0] timer_owner [TIMER_SLOTS];
   logic [COUNT_W-1:0] timer_left  [TIMER_SLOTS];
   logic [TICK_W-1:0]  tick_seen;
   expiry_rec_type     expiry_q [$];
   expiry_rec_type     want;
   int                 fail_count = 0;
   int                 pending_count = 0;

   assign mismatches       = fail_count;
   assign expiries_pending = pending_count;

   function automatic void clear_slot(int k);
      tbl_ident[k]   = '0;
      timer_owner[k] = '0;
      timer_left[k]  = '0;
   endfunction

   function automatic void compare_field(string name, longint want_val, longint got_val);
      if (want_val != got_val) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_val, got_val);
      end
   endfunction

   // Advance the timer table by one request; ticks queue their expiries in slot order.
   function automatic void apply_request(input logic [OPCODE_W-1:0] op,
                                         input logic [IDENT_W-1:0]  id,
                                         input logic [OWNER_W-1:0]  owner,
                                         input logic [COUNT_W-1:0]  dur,
                                         input logic [TICK_W-1:0]   now);
      logic [TICK_W-1:0]      elapsed;
      logic [TIMER_SLOTS-1:0] hits;
      expiry_rec_type         rec;
      int                     slot;
      slot = -1;
      case (op)
         OP_SET: begin
            if (id != '0) begin
               for (int k = 0; k < TIMER_SLOTS; k++)
                  if (slot < 0 && tbl_ident[k] == id && timer_owner[k] == owner) slot = k;
               if (slot < 0)
                  for (int k = 0; k < TIMER_SLOTS; k++)
                     if (slot < 0 && tbl_ident[k] == '0) slot = k;
               if (slot >= 0) begin
                  tbl_ident[slot]   = id;
                  timer_owner[slot] = owner;
                  timer_left[slot]  = dur;
               end
            end
         end
         OP_CANCEL: begin
            if (id != '0) begin
               for (int k = 0; k < TIMER_SLOTS; k++)
                  if (slot < 0 && tbl_ident[k] == id) slot = k;
               if (slot >= 0) clear_slot(slot);
            end
         end
         OP_TICK: begin
            elapsed   = now - tick_seen;
            tick_seen = now;
            hits      = '0;
            for (int k = 0; k < TIMER_SLOTS; k++) begin
               if (tbl_ident[k] != '0 && timer_left[k] != '0) begin
                  if (timer_left[k] > COUNT_W'(elapsed))
                     timer_left[k] = timer_left[k] - COUNT_W'(elapsed);
                  else
                     timer_left[k] = '0;
                  if (timer_left[k] == '0) hits[k] = 1'b1;
               end
            end
            for (int k = 0; k < TIMER_SLOTS; k++) begin
               if (hits[k]) begin
                  rec.ident    = tbl_ident[k];
                  rec.owner    = timer_owner[k];
                  rec.last_run = (hits >> (k + 1)) == '0;
                  expiry_q.push_back(rec);
                  clear_slot(k);
               end
            end
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TIMER_SLOTS; k++) clear_slot(k);
         tick_seen = '0;
         expiry_q.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expiry_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected expiry, expected none, actual id %0h owner %0h last %0b",
                        $time, rsp_bus.expired_timer, rsp_bus.expired_owner,
                        rsp_bus.last_of_run);
            end else begin
               want = expiry_q.pop_front();
               compare_field("expired_timer", want.ident, rsp_bus.expired_timer);
               compare_field("expired_owner", want.owner, rsp_bus.expired_owner);
               compare_field("last_of_run", want.last_run, rsp_bus.last_of_run);
            end
         end
         if (req_bus.valid && req_bus.ready)
            apply_request(req_bus.opcode, req_bus.timer_ident, req_bus.owner_task,
                          req_bus.duration, req_bus.now_tick);
      end
      pending_count = expiry_q.size();
   end

endmodule

FILE: tb/sv/tb.sv
// Testbench top for the software timer table: clock, reset, request and response
// stimulus with random idling, and the final verdict.
// Depends on stt_pkg, stt_ifaces, software_timer_table and stt_expiry_checker.
module tb import stt_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 110;
   localparam int HOLD_CYCLES  = 800;
   localparam int DRAIN_CYCLES = 2 * DEF_TIMER_SLOTS + 8;
   localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   quiet = 1'b0;
   bit   hold_request = 1'b0;
   int   mismatches;
   int   expiries_pending;

   logic [TICK_W-1:0]  tick_now = '0;
   logic [IDENT_W-1:0] id_pool [8];
   logic [OWNER_W-1:0] owner_pool [3];

   stt_req_if req_bus ();
   stt_rsp_if rsp_bus ();

   software_timer_table dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   stt_expiry_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .mismatches       (mismatches),
      .expiries_pending (expiries_pending)
   );

   always #2 clock = ~clock;

   initial begin
      #3_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // response side: random stalls, one long hold on demand
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [IDENT_W-1:0] id,
                               input logic [OWNER_W-1:0] owner, input logic [COUNT_W-1:0] dur,
                               input logic [TICK_W-1:0] now);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_bus.valid       <= 1'b0;
         req_bus.opcode      <= OPCODE_W'($urandom);
         req_bus.timer_ident <= IDENT_W'($urandom);
         req_bus.owner_task  <= OWNER_W'($urandom);
         req_bus.duration    <= $urandom;
         req_bus.now_tick    <= TICK_W'($urandom);
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.opcode      <= op;
      req_bus.timer_ident <= id;
      req_bus.owner_task  <= owner;
      req_bus.duration    <= dur;
      req_bus.now_tick    <= now;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_set(input logic [IDENT_W-1:0] id, input logic [OWNER_W-1:0] owner,
                           input logic [COUNT_W-1:0] dur);
      send_request(OP_SET, id, owner, dur, TICK_W'($urandom));
   endtask

   task automatic send_cancel(input logic [IDENT_W-1:0] id);
      send_request(OP_CANCEL, id, OWNER_W'($urandom), $urandom, TICK_W'($urandom));
   endtask

   task automatic send_tick(input logic [TICK_W-1:0] gap);
      tick_now = tick_now + gap;
      send_request(OP_TICK, IDENT_W'($urandom), OWNER_W'($urandom), $urandom, tick_now);
   endtask

   function automatic logic [IDENT_W-1:0] pick_ident();
      case ($urandom_range(0, 15))
         0:       return '0;
         1, 2:    return IDENT_W'($urandom);
         default: return id_pool[$urandom_range(0, 7)];
      endcase
   endfunction

   function automatic logic [OWNER_W-1:0] pick_owner();
      if ($urandom_range(0, 3) == 0) return OWNER_W'($urandom);
      return owner_pool[$urandom_range(0, 2)];
   endfunction

   function automatic logic [COUNT_W-1:0] pick_duration();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return $urandom;
         default: return COUNT_W'($urandom_range(1, 300));
      endcase
   endfunction

   function automatic logic [TICK_W-1:0] pick_gap();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return TICK_W'($urandom_range(0, 65535));
         default: return TICK_W'($urandom_range(1, 120));
      endcase
   endfunction

   initial begin
      int sent;
      int pick;
      req_bus.valid       <= 1'b0;
      req_bus.opcode      <= OP_SET;
      req_bus.timer_ident <= '0;
      req_bus.owner_task  <= '0;
      req_bus.duration    <= '0;
      req_bus.now_tick    <= '0;
      id_pool[0] = 16'h0001;
      id_pool[1] = 16'hFFFF;
      id_pool[2] = 16'h8000;
      for (int k = 3; k < 8; k++) id_pool[k] = IDENT_W'($urandom_range(1, 65535));
      owner_pool[0] = 8'h00;
      owner_pool[1] = 8'hFF;
      owner_pool[2] = OWNER_W'($urandom);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: ignored requests, reload, owner split, zero duration, wrap
      send_request(OP_SPARE, IDENT_W'($urandom), OWNER_W'($urandom), $urandom,
                   TICK_W'($urandom));
      send_set('0, 8'h11, 32'd5);
      send_cancel('0);
      send_set(16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
      send_set(16'h0001, 8'h00, 32'd0);
      send_set(16'h1234, 8'h05, 32'd3);
      send_set(16'h1234, 8'h05, 32'd10);
      send_set(16'h1234, 8'h06, 32'd2);
      send_tick(16'd0);
      send_tick(16'd5);
      send_cancel(16'h1234);
      send_cancel(16'h0001);
      send_set(16'h5A5A, 8'hA5, 32'd1);
      send_tick(16'hFFFA);
      send_set(16'h0002, 8'h03, 32'd4);
      send_tick(16'd5);
      send_cancel(16'hFFFF);

      // full table, dropped sets, then every slot expiring on one tick
      for (int k = 0; k < DEF_TIMER_SLOTS + 2; k++)
         send_set({k[4:0], 11'($urandom)} | 16'h0001, OWNER_W'($urandom),
                  COUNT_W'($urandom_range(1, 65535)));
      send_tick(16'hFFFF);

      // long response hold while requests keep coming
      hold_request = 1'b1;
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 4; k++)
            send_set(IDENT_W'($urandom_range(1, 65535)), OWNER_W'($urandom),
                     COUNT_W'($urandom_range(1, 3)));
         send_tick(16'd4);
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         quiet = (sent >= RANDOM_ITEMS - 40);
         sent++;
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            send_set(pick_ident(), pick_owner(), pick_duration());
         end else if (pick < 60) begin
            send_cancel(pick_ident());
         end else if (pick < 96) begin
            send_tick(pick_gap());
         end else begin
            send_request(OP_SPARE, IDENT_W'($urandom), OWNER_W'($urandom), $urandom,
                         TICK_W'($urandom));
         end
      end
      req_bus.valid <= 1'b0;

      do @(posedge clock); while (expiries_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
